@@ design/assert_macros.svh @@
// Assertion macros used by the scanner top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ails_pkg.sv @@
// Shared types and constants of the ASCII integer list scanner.
`timescale 1ns / 1ps

package ails_pkg;

    localparam int DEF_VALUE_BITS = 32;
    localparam int DEF_COUNT_BITS = 16;

    localparam int CAP_BITS = 16;
    localparam logic [CAP_BITS-1:0] CAP_RESET = '1;

    localparam int CMDQ_DEPTH = 4;
    localparam int OUTQ_DEPTH = 4;

    localparam int STAR_MAGNITUDE = 9999;

    localparam logic KIND_VALUE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_LOW_X = 8'h78;

    typedef struct packed {
        logic       nul;
        logic       star;
        logic       sign;
        logic       minus;
        logic       xch;
        logic       dec;
        logic       oct;
        logic       hex;
        logic       zero;
        logic [3:0] dval;
    } t_cls;

endpackage

@@ design/ascii_integer_list_scanner_unit.sv @@
// Top level of the ASCII integer list scanner.
// An accepted byte is registered in the command queue; the results it gives are registered in the
// four-entry result queue of the scan engine. Throughput: one byte per cycle unless the result
// queue backs up the command queue; a byte that closes a value and the string gives two results.
// Reset (synchronous, active low) empties both queues, returns the scanner to the between-token
// state with a zero count, and sets the buffer capacity to 65535.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ascii_integer_list_scanner_unit
    import ails_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CAP_BITS-1:0]   i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0: char_byte.
    input  logic [7:0]            s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0: int_value, value_index, stored, overflowed, zero fill.
    output logic [((VALUE_BITS+COUNT_BITS+2+7)/8)*8-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,
    // Fields from bit 0: item_kind.
    output logic                  m_axis_tuser
);

    localparam int OUT_TDATA_W = ((VALUE_BITS + COUNT_BITS + 2 + 7) / 8) * 8;

    t_cls                  w_cls;
    t_cls                  w_cmd;
    logic                  w_cmd_valid;
    logic                  w_cmd_ready;
    logic                  w_res_sum;
    logic [VALUE_BITS-1:0] w_res_value;
    logic [COUNT_BITS-1:0] w_res_index;
    logic                  w_res_stored;
    logic                  w_res_ovf;

    ails_front u_front (
        .i_byte (s_axis_tdata),
        .o_cls  (w_cls)
    );

    ails_cmd_queue u_cmd_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (s_axis_tvalid),
        .o_push_ready (s_axis_tready),
        .i_push_cmd   (w_cls),
        .o_pop_valid  (w_cmd_valid),
        .i_pop_ready  (w_cmd_ready),
        .o_pop_cmd    (w_cmd)
    );

    ails_back #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd_valid  (w_cmd_valid),
        .o_cmd_ready  (w_cmd_ready),
        .i_cmd        (w_cmd),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .o_res_sum    (w_res_sum),
        .o_res_value  (w_res_value),
        .o_res_index  (w_res_index),
        .o_res_stored (w_res_stored),
        .o_res_ovf    (w_res_ovf)
    );

    assign m_axis_tdata = OUT_TDATA_W'({w_res_ovf, w_res_stored, w_res_index, w_res_value});
    assign m_axis_tlast = w_res_sum;
    assign m_axis_tuser = w_res_sum ? KIND_SUMMARY : KIND_VALUE;

    `ASSERT_IMPLIES(a_summary_fields, m_axis_tvalid && m_axis_tlast, (m_axis_tdata[VALUE_BITS-1:0] == '0) && !m_axis_tdata[VALUE_BITS+COUNT_BITS], "Summary transaction carries a value or a stored flag.")
    `ASSERT_IMPLIES(a_kind_matches_last, m_axis_tvalid, m_axis_tlast == m_axis_tuser, "Item kind and last marker disagree.")
    `ASSERT_IMPLIES(a_stall_has_work, !s_axis_tready, w_cmd_valid, "Input stalled while the command queue is empty.")
    `ASSERT_NEXT(a_push_visible, s_axis_tvalid && s_axis_tready, w_cmd_valid, "Accepted byte did not reach the scan engine.")

endmodule

@@ design/ails_front.sv @@
// Byte classifier that turns each text byte into a scanner command.
`timescale 1ns / 1ps

module ails_front
    import ails_pkg::*;
(
    input  logic [7:0] i_byte,
    output t_cls       o_cls
);

    logic       w_upper;
    logic       w_lower;
    logic [7:0] w_dval;

    always_comb begin
        w_upper = i_byte inside {[CH_UP_A:CH_UP_F]};
        w_lower = i_byte inside {[CH_LOW_A:CH_LOW_F]};
        if (w_lower) begin
            w_dval = i_byte - CH_LOW_A + 8'd10;
        end else if (w_upper) begin
            w_dval = i_byte - CH_UP_A + 8'd10;
        end else begin
            w_dval = i_byte - CH_ZERO;
        end

        o_cls.nul   = (i_byte == CH_NUL);
        o_cls.star  = (i_byte == CH_STAR);
        o_cls.sign  = (i_byte == CH_PLUS) || (i_byte == CH_MINUS);
        o_cls.minus = (i_byte == CH_MINUS);
        o_cls.xch   = (i_byte == CH_LOW_X) || (i_byte == CH_UP_X);
        o_cls.dec   = i_byte inside {[CH_ZERO:CH_NINE]};
        o_cls.oct   = i_byte inside {[CH_ZERO:CH_SEVEN]};
        o_cls.hex   = o_cls.dec || w_upper || w_lower;
        o_cls.zero  = (i_byte == CH_ZERO);
        o_cls.dval  = w_dval[3:0];
    end

endmodule

@@ design/ails_cmd_queue.sv @@
// Short command queue between the classifier and the scan engine.
`timescale 1ns / 1ps

module ails_cmd_queue
    import ails_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cls i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cls o_pop_cmd
);

    localparam int AW = $clog2(CMDQ_DEPTH);
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    t_cls          r_mem [CMDQ_DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_push_ready = (r_cnt != CW'(CMDQ_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_mem[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + AW'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + AW'(1);
            end
            r_cnt <= r_cnt + CW'(w_push) - CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push_cmd;
        end
    end

endmodule

@@ design/ails_back.sv @@
// Scan engine that builds values and summaries and queues the results.
`timescale 1ns / 1ps

module ails_back
    import ails_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CAP_BITS-1:0]   i_cfg_wdata,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_ready,
    input  t_cls                  i_cmd,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic                  o_res_sum,
    output logic [VALUE_BITS-1:0] o_res_value,
    output logic [COUNT_BITS-1:0] o_res_index,
    output logic                  o_res_stored,
    output logic                  o_res_ovf
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_SIGN = 3'd1;
    localparam logic [2:0] PH_ZERO = 3'd2;
    localparam logic [2:0] PH_ZX   = 3'd3;
    localparam logic [2:0] PH_OCT  = 3'd4;
    localparam logic [2:0] PH_DEC  = 3'd5;
    localparam logic [2:0] PH_HEX  = 3'd6;
    localparam logic [2:0] PH_STAR = 3'd7;

    localparam int PW    = VALUE_BITS + 5;
    localparam int CMPW  = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;
    localparam int OQ_AW = $clog2(OUTQ_DEPTH);
    localparam int OQ_CW = $clog2(OUTQ_DEPTH + 1);

    localparam logic [VALUE_BITS-1:0] CAP_MAG  = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] POS_MAX  = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic                  STAR_SAT = (VALUE_BITS - 1) < $clog2(STAR_MAGNITUDE + 1);
    localparam logic [VALUE_BITS-1:0] STAR_MAG =
        STAR_SAT ? CAP_MAG : VALUE_BITS'(STAR_MAGNITUDE);

    logic [2:0]            r_phase, n_phase;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                  r_neg, n_neg;
    logic                  r_sat, n_sat;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_lost, n_lost;
    logic [CAP_BITS-1:0]   r_cap;

    logic                  r_oq_sum [OUTQ_DEPTH];
    logic [VALUE_BITS-1:0] r_oq_val [OUTQ_DEPTH];
    logic [COUNT_BITS-1:0] r_oq_idx [OUTQ_DEPTH];
    logic                  r_oq_sto [OUTQ_DEPTH];
    logic                  r_oq_ovf [OUTQ_DEPTH];
    logic [OQ_AW-1:0]      r_oq_wp;
    logic [OQ_AW-1:0]      r_oq_rp;
    logic [OQ_CW-1:0]      r_oq_cnt;

    logic                  w_take;
    logic                  w_pop;
    logic                  w_emit_val;
    logic                  w_emit_sum;
    logic                  w_use_star;
    logic                  w_as_idle;
    logic                  w_digit_ok;
    logic [PW-1:0]         w_ext;
    logic [PW-1:0]         w_prod;
    logic                  w_over;
    logic [VALUE_BITS-1:0] w_fmt_mag;
    logic                  w_fmt_neg;
    logic                  w_fmt_sat;
    logic [VALUE_BITS-1:0] w_val;
    logic                  w_val_ovf;
    logic                  w_cnt_full;
    logic                  w_val_sto;
    logic [COUNT_BITS-1:0] w_cnt_after;
    logic                  w_lost_after;
    logic [1:0]            w_push_n;
    logic                  w_a_sum;
    logic [VALUE_BITS-1:0] w_a_val;
    logic                  w_a_sto;
    logic                  w_a_ovf;

    assign o_cmd_ready = (r_oq_cnt <= OQ_CW'(OUTQ_DEPTH - 2));
    assign w_take      = i_cmd_valid && o_cmd_ready;
    assign o_res_valid = (r_oq_cnt != '0);
    assign w_pop       = o_res_valid && i_res_ready;

    assign o_res_sum    = r_oq_sum[r_oq_rp];
    assign o_res_value  = r_oq_val[r_oq_rp];
    assign o_res_index  = r_oq_idx[r_oq_rp];
    assign o_res_stored = r_oq_sto[r_oq_rp];
    assign o_res_ovf    = r_oq_ovf[r_oq_rp];

    always_comb begin
        w_ext = {5'b0, r_acc};
        case (r_phase)
            PH_OCT:  w_prod = (w_ext << 3) + PW'(i_cmd.dval);
            PH_HEX:  w_prod = (w_ext << 4) + PW'(i_cmd.dval);
            default: w_prod = (w_ext << 3) + (w_ext << 1) + PW'(i_cmd.dval);
        endcase
        w_over = (w_prod > PW'(CAP_MAG));

        case (r_phase)
            PH_OCT:  w_digit_ok = i_cmd.oct;
            PH_DEC:  w_digit_ok = i_cmd.dec;
            default: w_digit_ok = i_cmd.hex;
        endcase

        n_phase    = r_phase;
        n_acc      = r_acc;
        n_neg      = r_neg;
        n_sat      = r_sat;
        w_emit_val = 1'b0;
        w_emit_sum = 1'b0;
        w_use_star = 1'b0;
        w_as_idle  = 1'b0;

        case (r_phase)
            PH_SIGN: begin
                if (i_cmd.dec) begin
                    if (i_cmd.zero) begin
                        n_phase = PH_ZERO;
                    end else begin
                        n_phase = PH_DEC;
                        n_acc   = VALUE_BITS'(i_cmd.dval);
                    end
                end else begin
                    w_as_idle = 1'b1;
                end
            end
            PH_ZERO: begin
                if (i_cmd.xch) begin
                    n_phase = PH_ZX;
                end else if (i_cmd.oct) begin
                    n_phase = PH_OCT;
                    n_acc   = VALUE_BITS'(i_cmd.dval);
                end else begin
                    w_emit_val = 1'b1;
                    w_emit_sum = i_cmd.nul;
                    n_phase    = PH_IDLE;
                    n_acc      = '0;
                    n_neg      = 1'b0;
                    n_sat      = 1'b0;
                end
            end
            PH_ZX: begin
                if (i_cmd.hex) begin
                    n_phase = PH_HEX;
                    n_acc   = VALUE_BITS'(i_cmd.dval);
                end else begin
                    w_emit_val = 1'b1;
                    w_as_idle  = 1'b1;
                end
            end
            PH_OCT, PH_DEC, PH_HEX: begin
                if (w_digit_ok) begin
                    if (!r_sat) begin
                        if (w_over) begin
                            n_sat = 1'b1;
                        end else begin
                            n_acc = w_prod[VALUE_BITS-1:0];
                        end
                    end
                end else begin
                    w_emit_val = 1'b1;
                    w_emit_sum = i_cmd.nul;
                    n_phase    = PH_IDLE;
                    n_acc      = '0;
                    n_neg      = 1'b0;
                    n_sat      = 1'b0;
                end
            end
            PH_STAR: begin
                if (!i_cmd.star) begin
                    w_emit_val = 1'b1;
                    w_use_star = 1'b1;
                    w_emit_sum = i_cmd.nul;
                    n_phase    = PH_IDLE;
                    n_acc      = '0;
                    n_neg      = 1'b0;
                    n_sat      = 1'b0;
                end
            end
            default: begin
                w_as_idle = 1'b1;
            end
        endcase

        if (w_as_idle) begin
            n_phase = PH_IDLE;
            n_acc   = '0;
            n_neg   = 1'b0;
            n_sat   = 1'b0;
            if (i_cmd.nul) begin
                w_emit_sum = 1'b1;
            end else if (i_cmd.star) begin
                n_phase = PH_STAR;
            end else if (i_cmd.sign) begin
                n_phase = PH_SIGN;
                n_neg   = i_cmd.minus;
            end else if (i_cmd.dec) begin
                if (i_cmd.zero) begin
                    n_phase = PH_ZERO;
                end else begin
                    n_phase = PH_DEC;
                    n_acc   = VALUE_BITS'(i_cmd.dval);
                end
            end
        end

        w_fmt_mag = w_use_star ? STAR_MAG : r_acc;
        w_fmt_neg = w_use_star || r_neg;
        w_fmt_sat = w_use_star ? STAR_SAT : r_sat;
        if (w_fmt_neg) begin
            w_val     = '0 - (w_fmt_sat ? CAP_MAG : w_fmt_mag);
            w_val_ovf = w_fmt_sat;
        end else if (w_fmt_sat || w_fmt_mag[VALUE_BITS-1]) begin
            w_val     = POS_MAX;
            w_val_ovf = 1'b1;
        end else begin
            w_val     = w_fmt_mag;
            w_val_ovf = 1'b0;
        end

        w_cnt_full   = &r_count;
        w_val_sto    = (CMPW'(r_count) < CMPW'(r_cap));
        w_cnt_after  = (w_emit_val && !w_cnt_full) ? r_count + COUNT_BITS'(1) : r_count;
        w_lost_after = r_lost || (w_emit_val && w_cnt_full);
        n_count      = w_emit_sum ? '0 : w_cnt_after;
        n_lost       = w_emit_sum ? 1'b0 : w_lost_after;

        w_a_sum = !w_emit_val;
        w_a_val = w_emit_val ? w_val : '0;
        w_a_sto = w_emit_val && w_val_sto;
        w_a_ovf = w_emit_val ? (w_val_ovf || w_cnt_full) : w_lost_after;

        w_push_n = w_take ? (2'(w_emit_val) + 2'(w_emit_sum)) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_acc    <= '0;
            r_neg    <= 1'b0;
            r_sat    <= 1'b0;
            r_count  <= '0;
            r_lost   <= 1'b0;
            r_cap    <= CAP_RESET;
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (w_take) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_neg   <= n_neg;
                r_sat   <= n_sat;
                r_count <= n_count;
                r_lost  <= n_lost;
            end
            r_oq_wp  <= r_oq_wp + OQ_AW'(w_push_n);
            if (w_pop) begin
                r_oq_rp <= r_oq_rp + OQ_AW'(1);
            end
            r_oq_cnt <= r_oq_cnt + OQ_CW'(w_push_n) - OQ_CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_n != 2'd0) begin
            r_oq_sum[r_oq_wp] <= w_a_sum;
            r_oq_val[r_oq_wp] <= w_a_val;
            r_oq_idx[r_oq_wp] <= w_emit_val ? r_count : w_cnt_after;
            r_oq_sto[r_oq_wp] <= w_a_sto;
            r_oq_ovf[r_oq_wp] <= w_a_ovf;
        end
        if (w_push_n == 2'd2) begin
            r_oq_sum[r_oq_wp + OQ_AW'(1)] <= 1'b1;
            r_oq_val[r_oq_wp + OQ_AW'(1)] <= '0;
            r_oq_idx[r_oq_wp + OQ_AW'(1)] <= w_cnt_after;
            r_oq_sto[r_oq_wp + OQ_AW'(1)] <= 1'b0;
            r_oq_ovf[r_oq_wp + OQ_AW'(1)] <= w_lost_after;
        end
    end

endmodule

@@ verif/ails_scan_checker.sv @@
// Checker that predicts the scanner results from accepted text bytes and compares them.
`timescale 1ns / 1ps

module ails_scan_checker
    import ails_pkg::*;
#(
    parameter int TDATA_W = ((DEF_VALUE_BITS + DEF_COUNT_BITS + 2 + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CAP_BITS-1:0] i_cfg_wdata,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [7:0]          i_s_tdata,
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    input  logic [TDATA_W-1:0]  i_m_tdata,
    input  logic                i_m_tlast,
    input  logic                i_m_tuser,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_results
);

    localparam int VB = DEF_VALUE_BITS;
    localparam int CB = DEF_COUNT_BITS;
    localparam logic [63:0] MAG_CAP = 64'd1 << (VB - 1);
    localparam logic [63:0] VAL_MASK = (MAG_CAP << 1) - 64'd1;

    typedef enum logic [3:0] {
        SCAN_IDLE,
        SCAN_SIGN,
        SCAN_ZERO,
        SCAN_ZX,
        SCAN_OCT,
        SCAN_DEC,
        SCAN_HEX,
        SCAN_STAR
    } t_scan_phase;

    typedef struct packed {
        logic          kind;
        logic [VB-1:0] value;
        logic [CB-1:0] index;
        logic          stored;
        logic          ovf;
        logic          last;
    } t_scan_result;

    t_scan_result        expected_q[$];
    logic [CAP_BITS-1:0] capacity;
    t_scan_phase         phase;
    logic [63:0]         magnitude;
    logic                negative;
    logic                saturated;
    logic                count_lost;
    logic [CB-1:0]       value_count;

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return int'(c - CH_ZERO);
        end
        if (c >= CH_LOW_A && c <= CH_LOW_F) begin
            return int'(c - CH_LOW_A) + 10;
        end
        if (c >= CH_UP_A && c <= CH_UP_F) begin
            return int'(c - CH_UP_A) + 10;
        end
        return -1;
    endfunction

    task automatic clear_token();
        phase = SCAN_IDLE;
        magnitude = '0;
        negative = 1'b0;
        saturated = 1'b0;
    endtask

    task automatic add_digit(input logic [63:0] base, input logic [63:0] d);
        if (!saturated) begin
            if (magnitude > (MAG_CAP - d) / base) begin
                saturated = 1'b1;
            end else begin
                magnitude = magnitude * base + d;
            end
        end
    endtask

    task automatic start_digit(input logic [7:0] c);
        if (c == CH_ZERO) begin
            phase = SCAN_ZERO;
        end else begin
            phase = SCAN_DEC;
            magnitude = 64'(c - CH_ZERO);
        end
    endtask

    task automatic emit_value();
        logic [63:0]  m;
        logic [63:0]  v;
        logic         ovf;
        t_scan_result r;
        m = magnitude;
        ovf = saturated;
        if (negative) begin
            if (saturated) begin
                m = MAG_CAP;
            end
            v = (64'd0 - m) & VAL_MASK;
        end else begin
            if (saturated || m > MAG_CAP - 64'd1) begin
                m = MAG_CAP - 64'd1;
                ovf = 1'b1;
            end
            v = m;
        end
        r.kind = KIND_VALUE;
        r.value = v[VB-1:0];
        r.index = value_count;
        r.stored = (CAP_BITS'(value_count) < capacity);
        if (value_count == '1) begin
            count_lost = 1'b1;
            ovf = 1'b1;
        end else begin
            value_count = value_count + 1'b1;
        end
        r.ovf = ovf;
        r.last = 1'b0;
        expected_q.push_back(r);
        clear_token();
    endtask

    task automatic emit_summary();
        t_scan_result r;
        r.kind = KIND_SUMMARY;
        r.value = '0;
        r.index = value_count;
        r.stored = 1'b0;
        r.ovf = count_lost;
        r.last = 1'b1;
        expected_q.push_back(r);
        clear_token();
        value_count = '0;
        count_lost = 1'b0;
    endtask

    task automatic scan_byte(input logic [7:0] c);
        int n;
        bit again;
        int h;
        n = 0;
        again = 1'b1;
        while (again && n < 2) begin
            again = 1'b0;
            case (phase)
                SCAN_SIGN: begin
                    if (c >= CH_ZERO && c <= CH_NINE) begin
                        start_digit(c);
                    end else begin
                        clear_token();
                        again = 1'b1;
                    end
                end
                SCAN_ZERO: begin
                    if (c == CH_LOW_X || c == CH_UP_X) begin
                        phase = SCAN_ZX;
                    end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
                        phase = SCAN_OCT;
                        magnitude = 64'(c - CH_ZERO);
                    end else begin
                        emit_value();
                        n++;
                        if (c == CH_NUL) begin
                            emit_summary();
                            n++;
                        end
                    end
                end
                SCAN_ZX: begin
                    h = hex_digit(c);
                    if (h >= 0) begin
                        phase = SCAN_HEX;
                        magnitude = 64'(h);
                    end else begin
                        emit_value();
                        n++;
                        again = 1'b1;
                    end
                end
                SCAN_OCT, SCAN_DEC, SCAN_HEX: begin
                    h = hex_digit(c);
                    if (phase == SCAN_OCT && h >= 0 && h < 8) begin
                        add_digit(64'd8, 64'(h));
                    end else if (phase == SCAN_DEC && h >= 0 && h < 10) begin
                        add_digit(64'd10, 64'(h));
                    end else if (phase == SCAN_HEX && h >= 0) begin
                        add_digit(64'd16, 64'(h));
                    end else begin
                        emit_value();
                        n++;
                        if (c == CH_NUL) begin
                            emit_summary();
                            n++;
                        end
                    end
                end
                SCAN_STAR: begin
                    if (c != CH_STAR) begin
                        negative = 1'b1;
                        saturated = 1'b0;
                        magnitude = '0;
                        add_digit(64'd10000, 64'(STAR_MAGNITUDE));
                        emit_value();
                        n++;
                        if (c == CH_NUL) begin
                            emit_summary();
                            n++;
                        end
                    end
                end
                default: begin
                    clear_token();
                    if (c == CH_NUL) begin
                        emit_summary();
                        n++;
                    end else if (c == CH_STAR) begin
                        phase = SCAN_STAR;
                    end else if (c == CH_PLUS || c == CH_MINUS) begin
                        phase = SCAN_SIGN;
                        negative = (c == CH_MINUS);
                    end else if (c >= CH_ZERO && c <= CH_NINE) begin
                        start_digit(c);
                    end
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        t_scan_result got;
        t_scan_result want;
        if (!i_rst_n) begin
            capacity = CAP_RESET;
            clear_token();
            value_count = '0;
            count_lost = 1'b0;
            expected_q.delete();
            o_fail_count = 0;
            o_results = 0;
        end else begin
            if (i_cfg_we) begin
                capacity = i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready) begin
                scan_byte(i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.kind = i_m_tuser;
                got.value = i_m_tdata[VB-1:0];
                got.index = i_m_tdata[VB+CB-1:VB];
                got.stored = i_m_tdata[VB+CB];
                got.ovf = i_m_tdata[VB+CB+1];
                got.last = i_m_tlast;
                if (expected_q.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("Unexpected result: kind %0d value %0d index %0d stored %0d ovf %0d last %0d",
                                 got.kind, $signed(got.value), got.index, got.stored, got.ovf,
                                 got.last);
                    end
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.kind !== want.kind || got.value !== want.value ||
                        got.index !== want.index || got.stored !== want.stored ||
                        got.ovf !== want.ovf || got.last !== want.last) begin
                        if (o_fail_count < 10) begin
                            $display("Mismatch on result %0d:", o_results);
                            $display("  expected kind %0d value %0d index %0d stored %0d ovf %0d last %0d",
                                     want.kind, $signed(want.value), want.index, want.stored,
                                     want.ovf, want.last);
                            $display("  actual   kind %0d value %0d index %0d stored %0d ovf %0d last %0d",
                                     got.kind, $signed(got.value), got.index, got.stored, got.ovf,
                                     got.last);
                        end
                        o_fail_count++;
                    end
                end
                o_results++;
            end
        end
        o_pending = expected_q.size();
    end

endmodule

@@ verif/tb_top.sv @@
// Testbench top that drives text strings into the scanner and reports the verdict.
`timescale 1ns / 1ps

module tb_top;
    import ails_pkg::*;

    localparam int TDATA_W = ((DEF_VALUE_BITS + DEF_COUNT_BITS + 2 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_BYTES = 340;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CAP_BITS-1:0] cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic [7:0]          s_tdata = '0;
    logic                m_tready = 1'b0;
    logic                s_tready;
    logic                m_tvalid;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tlast;
    logic                m_tuser;

    int fail_count;
    int pending;
    int results;
    int idle_max = 19;
    int hold_requests = 0;
    int bytes_sent = 0;
    int strings_sent = 0;
    int cap_writes = 0;
    int cycle_count = 0;

    string edge_tokens[9] = '{
        "2147483647", "2147483648", "-2147483648", "-2147483649", "0x7fffffff",
        "0X80000000", "-0x80000000", "017777777777", "020000000000"
    };

    always #1 i_clk = ~i_clk;

    ascii_integer_list_scanner_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast),
        .m_axis_tuser  (m_tuser)
    );

    ails_scan_checker #(
        .TDATA_W (TDATA_W)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results)
    );

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ascii_integer_list_scanner_unit regression: fail");
            $finish;
        end
    end

    // Result side: a random wait before each transaction, and a long hold-off on request.
    initial begin
        int gap;
        int holds_done;
        holds_done = 0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = $urandom_range(0, idle_max);
            if (hold_requests > holds_done) begin
                holds_done++;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            @(negedge i_clk);
        end
    end

    function automatic logic [7:0] hex_char(input int v, input bit upper);
        if (v < 10) begin
            return CH_ZERO + 8'(v);
        end
        return (upper ? CH_UP_A : CH_LOW_A) + 8'(v - 10);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge i_clk); while (!s_tready);
        bytes_sent++;
        if (b == CH_NUL) begin
            strings_sent++;
        end
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    task automatic send_separator();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) begin
            send_byte(" ");
        end else if (r < 15) begin
            send_byte(8'($urandom_range(9, 13)));
        end else if (r < 17) begin
            send_byte(",");
        end else begin
            send_byte(8'($urandom_range(1, 255)));
        end
    endtask

    task automatic send_token();
        int kind;
        int n;
        int i;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            if ($urandom_range(0, 3) == 0) begin
                send_byte($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            end
            n = $urandom_range(1, ($urandom_range(0, 5) == 0) ? 12 : 4);
            send_byte(hex_char($urandom_range(1, 9), 1'b0));
            for (i = 1; i < n; i++) begin
                send_byte(hex_char($urandom_range(0, 9), 1'b0));
            end
        end else if (kind < 42) begin
            send_byte(CH_ZERO);
            n = $urandom_range(0, 11);
            for (i = 0; i < n; i++) begin
                send_byte(hex_char($urandom_range(0, 7), 1'b0));
            end
            if ($urandom_range(0, 4) == 0) begin
                send_byte(hex_char($urandom_range(8, 9), 1'b0));
            end
        end else if (kind < 57) begin
            send_byte(CH_ZERO);
            send_byte($urandom_range(0, 1) ? CH_UP_X : CH_LOW_X);
            n = $urandom_range(1, 9);
            for (i = 0; i < n; i++) begin
                send_byte(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
            end
        end else if (kind < 65) begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) begin
                send_byte(CH_STAR);
            end
        end else if (kind < 75) begin
            send_text(edge_tokens[$urandom_range(0, 8)]);
        end else if (kind < 82) begin
            send_byte($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        end else if (kind < 88) begin
            send_byte(CH_ZERO);
            send_byte($urandom_range(0, 1) ? CH_UP_X : CH_LOW_X);
        end else begin
            send_byte(8'($urandom_range(1, 255)));
        end
    endtask

    task automatic send_random_string();
        int ntok;
        int t;
        ntok = $urandom_range(0, 8);
        for (t = 0; t < ntok; t++) begin
            send_token();
            if (t < ntok - 1 || $urandom_range(0, 2) != 0) begin
                send_separator();
            end
        end
        send_byte(CH_NUL);
    endtask

    task automatic write_capacity(input logic [CAP_BITS-1:0] value);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        cap_writes++;
    endtask

    initial begin
        logic [CAP_BITS-1:0] caps[5];
        int p;
        int target;
        caps = '{16'd0, 16'd65535, 16'd1, 16'd5, 16'($urandom_range(6, 65534))};
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Sign without digit, 0x without hex digit, a 9 after a zero, a star run
        // ended by byte 255, a dropped high byte, saturation, and NUL inside a token.
        send_text("-+5 0xg09**");
        send_byte(8'hFF);
        send_byte(8'h80);
        send_text("99999999999");
        send_byte(CH_NUL);

        for (p = 0; p < 5; p++) begin
            write_capacity(caps[p]);
            idle_max = (p % 2 == 0) ? 19 : 0;
            if (p == 1) begin
                hold_requests++;
            end
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) begin
                send_random_string();
            end
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Scanned %0d bytes in %0d strings under %0d capacity settings,",
                 bytes_sent, strings_sent, cap_writes + 1);
        $display("including saturation and a long output hold-off; %0d results compared.",
                 results);
        if (fail_count == 0 && pending == 0) begin
            $display("ascii_integer_list_scanner_unit regression: pass");
        end else begin
            $display("ascii_integer_list_scanner_unit regression: fail");
        end
        $finish;
    end

endmodule
